/* design/dda_pkg.sv */
// ----------------------------------------------------------------------------
// dda_pkg
// Types, widths and the axis step function shared by the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

	localparam int SCREEN_WIDTH = 64;

	localparam int COORD_W = 6;
	localparam int ADDR_W  = 12;
	localparam int COLOR_W = 32;
	localparam int SIDE2_W = COORD_W + 1;
	localparam int D2_W    = COORD_W + 2;
	localparam int REM_W   = COORD_W + 3;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [COLOR_W-1:0] line_color;
	} segment_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic               last_pixel;
	} pixel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DRAW
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0]      coord;
		logic signed [REM_W-1:0] rem;
	} axis_t;

	typedef struct packed {
		logic signed [D2_W-1:0]  dx2;
		logic signed [D2_W-1:0]  dy2;
		logic [COORD_W-1:0]      side;
		logic [SIDE2_W-1:0]      side2;
		logic signed [REM_W-1:0] rem0;
	} setup_t;

	// advance one axis by one step along the long axis
	function automatic axis_t axis_step(axis_t cur, logic signed [D2_W-1:0] d2,
			logic [SIDE2_W-1:0] side2);
		logic signed [REM_W-1:0] sum;
		logic signed [REM_W-1:0] lim;
		axis_t                   nxt;
		sum = cur.rem + REM_W'(d2);
		lim = $signed(REM_W'(side2));
		nxt = cur;
		if (sum >= lim) begin
			nxt.rem   = sum - lim;
			nxt.coord = cur.coord + COORD_W'(1);
		end else if (sum < $signed(REM_W'(0))) begin
			nxt.rem   = sum + lim;
			nxt.coord = cur.coord - COORD_W'(1);
		end else begin
			nxt.rem = sum;
		end
		return nxt;
	endfunction

endpackage

/* design/dda_setup.sv */
// ----------------------------------------------------------------------------
// dda_setup
// Segment set-up: signed deltas, long-axis length and initial remainder.
// ----------------------------------------------------------------------------
module dda_setup import dda_pkg::*; (
	input  segment_t seg,
	output setup_t   setup
);

	logic signed [COORD_W:0] dx;
	logic signed [COORD_W:0] dy;
	logic [COORD_W-1:0]      adx;
	logic [COORD_W-1:0]      ady;
	logic [COORD_W-1:0]      side;

	always_comb begin
		dx   = $signed({1'b0, seg.end_x}) - $signed({1'b0, seg.start_x});
		dy   = $signed({1'b0, seg.end_y}) - $signed({1'b0, seg.start_y});
		adx  = dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
		ady  = dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
		side = (adx >= ady) ? adx : ady;
		setup.dx2   = {dx, 1'b0};
		setup.dy2   = {dy, 1'b0};
		setup.side  = side;
		setup.side2 = {side, 1'b0};
		setup.rem0  = $signed(REM_W'(side));
	end

endmodule

/* design/dda_step.sv */
// ----------------------------------------------------------------------------
// dda_step
// Stepping unit: advances both axes by one pixel along the long axis.
// ----------------------------------------------------------------------------
module dda_step import dda_pkg::*; (
	input  axis_t  cur_x,
	input  axis_t  cur_y,
	input  setup_t setup,
	output axis_t  nxt_x,
	output axis_t  nxt_y
);

	always_comb begin
		nxt_x = axis_step(cur_x, setup.dx2, setup.side2);
		nxt_y = axis_step(cur_y, setup.dy2, setup.side2);
	end

endmodule

/* design/dda_line_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// DDA line rasterizer: one segment in, one pixel write per cycle out while drawing.
// ----------------------------------------------------------------------------
//  channel   handshake              word
//  -------   ---------------------  ------------------------------------
//  segment   start & !busy          two endpoints and a color
//  pixel     strobe (one cycle)     x, y, address, color, last marker
//
//  A segment holds busy through the set-up state, then through the draw
//  state, with one pixel per cycle from the stepping unit.
//  Pixels appear in the cycle after their position is held in the axis registers, from the output register.
//  Reset returns the sequencer to idle and drops any pending pixel.
//  The receiver cannot stall; strobe marks each word for one cycle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core import dda_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  segment_t segment,
	output logic     busy,
	output logic     strobe,
	output pixel_t   pixel
);

	state_t   state_q;
	state_t   state_nxt;
	segment_t seg_q;
	setup_t   setup_c;
	setup_t   setup_q;
	axis_t    ax_q;
	axis_t    ay_q;
	axis_t    ax_nxt;
	axis_t    ay_nxt;
	logic [COORD_W-1:0] cnt_q;
	logic     last_c;
	logic     strobe_q;
	pixel_t   pixel_q;

	dda_setup u_setup (
		.seg   (seg_q),
		.setup (setup_c)
	);

	dda_step u_step (
		.cur_x (ax_q),
		.cur_y (ay_q),
		.setup (setup_q),
		.nxt_x (ax_nxt),
		.nxt_y (ay_nxt)
	);

	assign last_c = (cnt_q == setup_q.side);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nxt = ST_SETUP;
			ST_SETUP: state_nxt = ST_DRAW;
			ST_DRAW:  if (last_c) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= (state_q == ST_DRAW);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			seg_q <= segment;
		end
		if (state_q == ST_SETUP) begin
			setup_q  <= setup_c;
			ax_q     <= '{coord: seg_q.start_x, rem: setup_c.rem0};
			ay_q     <= '{coord: seg_q.start_y, rem: setup_c.rem0};
			cnt_q    <= '0;
		end else if (state_q == ST_DRAW) begin
			ax_q  <= ax_nxt;
			ay_q  <= ay_nxt;
			cnt_q <= cnt_q + COORD_W'(1);
		end
		if (state_q == ST_DRAW) begin
			pixel_q.pixel_x       <= ax_q.coord;
			pixel_q.pixel_y       <= ay_q.coord;
			pixel_q.pixel_address <= ADDR_W'(ADDR_W'(ay_q.coord) * ADDR_W'(SCREEN_WIDTH)
				+ ADDR_W'(ax_q.coord));
			pixel_q.pixel_color   <= seg_q.line_color;
			pixel_q.last_pixel    <= last_c;
		end
	end

	assign strobe = strobe_q;
	assign pixel  = pixel_q;

`ifndef SYNTHESIS
	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && pixel.last_pixel)
		else $error("busy dropped without a last pixel");

	a_no_word_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !strobe)
		else $error("pixel word right after segment accept");

	a_busy_mid_line: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !pixel.last_pixel |-> busy)
		else $error("idle while a segment is unfinished");
`endif

endmodule
